// ===== design/gwm_pkg.sv =====
// Shared types, constants and helper functions for the weighted Gram matrix block.
`timescale 1ns / 1ps
package gwm_pkg;
	localparam int MAX_COLS  = 8;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int CNT_W     = COL_W + 1;
	localparam int ADDR_W    = 2 * COL_W;
	localparam int SUM_DEPTH = MAX_COLS * MAX_COLS;
	localparam int X_W       = 16;
	localparam int W_W       = 16;
	localparam int SUM_W     = 64;
	localparam int PROD_W    = 2 * X_W;
	localparam int TERM_W    = PROD_W + W_W + 1;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_ROOT = 2'd1;

	localparam logic [0:0] REG_NUM_COLS    = 1'b0;
	localparam logic [0:0] REG_WEIGHT_MODE = 1'b1;

	typedef logic [MAX_COLS-1:0][X_W-1:0] row_vec_t;

	typedef struct packed {
		row_vec_t         row;
		logic [W_W-1:0]   weight;
		logic [CNT_W-1:0] cols;
		logic [1:0]       mode;
		logic             eom;
	} job_t;

	function automatic logic [CNT_W-1:0] eff_cols(input logic [3:0] n);
		logic [CNT_W-1:0] r;
		if (n == 4'd0)
			r = CNT_W'(1);
		else if (32'(n) > MAX_COLS)
			r = CNT_W'(MAX_COLS);
		else
			r = CNT_W'(n);
		return r;
	endfunction

	function automatic logic [W_W-1:0] eff_weight(input logic [1:0] mode,
		input logic [W_W-1:0] w);
		logic [2*W_W:0]   sq;
		logic [2*W_W-8:0] sh;
		logic [W_W-1:0]   r;
		sq = (2*W_W+1)'(w) * (2*W_W+1)'(w) + (2*W_W+1)'(128);
		sh = sq[2*W_W:8];
		if (mode == MODE_NONE)
			r = W_W'(256);
		else if (mode == MODE_ROOT)
			r = w;
		else if (|sh[2*W_W-8:W_W])
			r = {W_W{1'b1}};
		else
			r = sh[W_W-1:0];
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
		input logic signed [TERM_W-1:0] b);
		logic signed [SUM_W:0] s;
		logic [SUM_W-1:0]      r;
		s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
		if (s[SUM_W] != s[SUM_W-1])
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			r = s[SUM_W-1:0];
		return r;
	endfunction
endpackage

// ===== design/gwm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module gwm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== design/gwm_front.sv =====
// Front end: collects row elements and hands finished rows to the job queue.
`timescale 1ns / 1ps
module gwm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [15:0]          x_value,
	input  logic [15:0]          row_weight,
	input  logic                 end_of_row,
	input  logic                 end_of_matrix,
	input  logic [3:0]           num_cols,
	input  logic [1:0]           weight_mode,
	input  logic                 q_full,
	output logic                 job_push,
	output gwm_pkg::job_t        job
);
	gwm_pkg::row_vec_t             row_q, row_next;
	logic [gwm_pkg::CNT_W-1:0]     col_pos_q, col_next, p;
	logic                          accept, row_end;

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign row_end = end_of_row || end_of_matrix;
	assign p       = gwm_pkg::eff_cols(num_cols);

	always_comb begin
		row_next = row_q;
		col_next = p;
		if (col_pos_q < p) begin
			row_next[col_pos_q[gwm_pkg::COL_W-1:0]] = x_value;
			col_next = col_pos_q + gwm_pkg::CNT_W'(1);
		end
	end

	assign job_push   = accept && row_end;
	assign job.row    = row_next;
	assign job.weight = row_weight;
	assign job.cols   = p;
	assign job.mode   = weight_mode;
	assign job.eom    = end_of_matrix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_pos_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				row_q     <= '0;
				col_pos_q <= '0;
			end else begin
				row_q     <= row_next;
				col_pos_q <= col_next;
			end
		end
	end
endmodule

// ===== design/gwm_job_queue.sv =====
// Two-entry queue of finished rows between front and back.
`timescale 1ns / 1ps
module gwm_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gwm_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gwm_pkg::job_t head
);
	gwm_pkg::job_t slot_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full)
				wptr_q <= !wptr_q;
			if (pop && !empty)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== design/gwm_back.sv =====
// Back end: weighted multiply-accumulate over the sum store and result dump.
`timescale 1ns / 1ps
module gwm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  gwm_pkg::job_t        q_head,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           out_row,
	output logic [2:0]           out_col,
	output logic [63:0]          sum_value,
	output logic                 last
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WGT   = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DUMP  = 3'd4;

	localparam int CW = gwm_pkg::COL_W;
	localparam int AW = gwm_pkg::ADDR_W;

	logic [2:0]                     state_q;
	gwm_pkg::row_vec_t              jrow_q, rowq_q, colq_q;
	logic [gwm_pkg::W_W-1:0]        w_q, we_q;
	logic [gwm_pkg::CNT_W-1:0]      p_q;
	logic [1:0]                     mode_q;
	logic                           eom_q;
	logic [CW-1:0]                  i_q, j_q;
	logic                           last_i, last_j;

	logic                           run_issue, dump_issue, re;
	logic [AW-1:0]                  raddr;
	logic [gwm_pkg::SUM_W-1:0]      rdata, wdata;
	logic [gwm_pkg::SUM_DEPTH-1:0]  vld_q;

	logic                           v_s1_q, v_s2_q, vld_s1;
	logic [AW-1:0]                  k_s1, k_s2;
	logic signed [gwm_pkg::PROD_W-1:0] prod_s1;
	logic signed [gwm_pkg::TERM_W-1:0] term_s2;
	logic [gwm_pkg::SUM_W-1:0]      old_s2;

	logic                           rd_pend_q, issued_all_q, out_valid_q;
	logic [CW-1:0]                  rd_i_s1, rd_j_s1;
	logic                           rd_last_s1;

	assign last_j = ({1'b0, j_q} + gwm_pkg::CNT_W'(1)) == p_q;
	assign last_i = ({1'b0, i_q} + gwm_pkg::CNT_W'(1)) == p_q;

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign run_issue  = state_q == ST_RUN;
	assign dump_issue = (state_q == ST_DUMP) && !rd_pend_q && !issued_all_q
		&& (!out_valid_q || pop);
	assign re         = run_issue || dump_issue;
	assign raddr      = {i_q, j_q};
	assign wdata      = gwm_pkg::sat_add(old_s2, term_s2);
	assign empty      = !out_valid_q;

	gwm_ram #(.WIDTH(gwm_pkg::SUM_W), .DEPTH(gwm_pkg::SUM_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (v_s2_q),
		.waddr (k_s2),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			jrow_q <= q_head.row;
			w_q    <= q_head.weight;
			p_q    <= q_head.cols;
			mode_q <= q_head.mode;
			eom_q  <= q_head.eom;
		end
		if (state_q == ST_WGT) begin
			we_q   <= gwm_pkg::eff_weight(mode_q, w_q);
			rowq_q <= jrow_q;
			colq_q <= jrow_q;
		end else if (run_issue) begin
			if (last_j) begin
				colq_q <= jrow_q;
				rowq_q <= {{gwm_pkg::X_W{1'b0}}, rowq_q[gwm_pkg::MAX_COLS-1:1]};
			end else begin
				colq_q <= {{gwm_pkg::X_W{1'b0}}, colq_q[gwm_pkg::MAX_COLS-1:1]};
			end
		end
		if (run_issue) begin
			prod_s1 <= $signed(rowq_q[0]) * $signed(colq_q[0]);
			k_s1    <= raddr;
		end
		if (re)
			vld_s1 <= vld_q[raddr];
		term_s2 <= prod_s1 * $signed({1'b0, we_q});
		old_s2  <= vld_s1 ? rdata : '0;
		k_s2    <= k_s1;
		if (dump_issue) begin
			rd_i_s1    <= i_q;
			rd_j_s1    <= j_q;
			rd_last_s1 <= last_i && last_j;
		end
		if (rd_pend_q) begin
			out_row   <= rd_i_s1;
			out_col   <= rd_j_s1;
			sum_value <= vld_s1 ? rdata : '0;
			last      <= rd_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			vld_q        <= '0;
			rd_pend_q    <= 1'b0;
			issued_all_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1_q <= run_issue;
			v_s2_q <= v_s1_q;
			if (v_s2_q)
				vld_q[k_s2] <= 1'b1;
			if (rd_pend_q)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty)
						state_q <= ST_WGT;
				end
				ST_WGT: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							i_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1_q && !v_s2_q) begin
						issued_all_q <= 1'b0;
						state_q      <= eom_q ? ST_DUMP : ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (dump_issue) begin
						rd_pend_q <= 1'b1;
						if (last_j) begin
							j_q <= '0;
							if (last_i)
								issued_all_q <= 1'b1;
							else
								i_q <= i_q + CW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
					end
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						if (rd_last_s1) begin
							vld_q   <= '0;
							i_q     <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_write_only_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("sum store write outside accumulation");
	a_no_out_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid_q)
		else $error("result register overwritten");
	a_dump_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (!v_s1_q && !v_s2_q))
		else $error("dump started with accumulation in flight");
	a_pop_starts_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_WGT))
		else $error("row job taken without starting");
endmodule

// ===== design/weighted_gram_matrix.sv =====
// Top level: streaming weighted Gram matrix accumulator with APB configuration.
// The back end forms the p*p weighted products of each finished row in the single MAC pipe.
// The front keeps taking elements while the back end is busy, until the job queue is full.
// Matrix end: the p*p results follow the last row from the sum store, one at a time as popped.
// The front holds off (full) only when both row slots of the job queue are occupied.
// Reset (arst_n low): row, counters, queue, sum-store valid bits cleared; num_cols=8, weight_mode=0.
`timescale 1ns / 1ps
module weighted_gram_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] x_value,
	input  logic [15:0] row_weight,
	input  logic        end_of_row,
	input  logic        end_of_matrix,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_row,
	output logic [2:0]  out_col,
	output logic [63:0] sum_value,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0]    num_cols_q;
	logic [1:0]    weight_mode_q;
	logic          cfg_wr;
	logic          q_full, q_empty, q_push, q_pop;
	gwm_pkg::job_t push_job, head_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == gwm_pkg::REG_WEIGHT_MODE) ? {30'd0, weight_mode_q}
		: {28'd0, num_cols_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q    <= 4'd8;
			weight_mode_q <= gwm_pkg::MODE_NONE;
		end else if (cfg_wr) begin
			if (paddr[2] == gwm_pkg::REG_NUM_COLS)
				num_cols_q <= pwdata[3:0];
			else
				weight_mode_q <= pwdata[1:0];
		end
	end

	gwm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.x_value       (x_value),
		.row_weight    (row_weight),
		.end_of_row    (end_of_row),
		.end_of_matrix (end_of_matrix),
		.num_cols      (num_cols_q),
		.weight_mode   (weight_mode_q),
		.q_full        (q_full),
		.job_push      (q_push),
		.job           (push_job)
	);

	gwm_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	gwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_job),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_row   (out_row),
		.out_col   (out_col),
		.sum_value (sum_value),
		.last      (last)
	);
endmodule
